>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bal_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array list package
// Types, codes and constants shared by the list cells and the top level.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned CNT_OUT_W    = 6;
  localparam logic signed [15:0] BAD_X = -16'sd99;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_GET       = 3'd2,
    OP_SET       = 3'd3,
    OP_READ_NEXT = 3'd4,
    OP_RESET_PTR = 3'd5
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_END   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        num;
    logic [7:0]         flag;
    logic [7:0]         symbol;
  } rec_t;

  typedef struct packed {
    cell_op_e op;
    logic     hit;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [IDX_W-1:0]   index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        pos_num;
    logic [7:0]         pos_flag;
    logic [7:0]         pos_symbol;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [15:0]   out_x;
    logic signed [15:0]   out_y;
    logic [15:0]          out_num;
    logic [7:0]           out_flag;
    logic [7:0]           out_symbol;
    logic [CNT_OUT_W-1:0] count;
  } out_item_t;

endpackage

>>> sv/bal_chan_if.sv
// ----------------------------------------------------------------------------
// Bounded array list channel
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface bal_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/bal_cell.sv
// ----------------------------------------------------------------------------
// Bounded array list cell
// Holds one record; loads a new record or takes a neighbor's record.
// ----------------------------------------------------------------------------
module bal_cell (
  input  logic                clk_i,
  input  bal_pkg::cell_ctrl_t ctrl_i,
  input  bal_pkg::rec_t       new_rec_i,
  input  bal_pkg::rec_t       lower_rec_i,
  input  bal_pkg::rec_t       upper_rec_i,
  output bal_pkg::rec_t       rec_o,
  output bal_pkg::rec_t       rd_rec_o
);

  bal_pkg::rec_t rec_q;
  bal_pkg::rec_t rec_d;

  always_comb begin
    unique case (ctrl_i.op)
      bal_pkg::CELL_LOAD:       rec_d = new_rec_i;
      bal_pkg::CELL_SHIFT_UP:   rec_d = lower_rec_i;
      bal_pkg::CELL_SHIFT_DOWN: rec_d = upper_rec_i;
      default:                  rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o    = rec_q;
  assign rd_rec_o = ctrl_i.hit ? rec_q : '0;

endmodule

>>> sv/bounded_array_list.sv
// ----------------------------------------------------------------------------
// Bounded array list
// Ordered list of up to CAPACITY records held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per transaction: insert, remove, get, set,
//   read next, reset read pointer. out_o returns exactly one result per
//   operation: status, the returned record and the record count.
//   For every operation the cells shift, load or hold in the cycle the
//   transaction is accepted; the result is registered and shown on out_o in
//   the next cycle. One operation per cycle is sustained unless out_o stalls.
//   The read of a record is a one-hot select across the cells, OR-combined
//   into the output register.
//   When out_o is stalled, the result holds in the output register and in_i
//   drops ready until the result is taken; ready stays high while the output
//   register is empty or being drained.
//   Reset clears the count, the read pointer and the output valid. Record
//   contents are not cleared; only records below the count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_array_list #(
  parameter int unsigned CAPACITY = bal_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bal_chan_if.sink   in_i,
  bal_chan_if.source out_o
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned IW    = bal_pkg::IDX_W;
  localparam int unsigned CMP_W = (CW > IW) ? CW : IW;

  logic [CW-1:0]       count_q;
  logic [CW-1:0]       count_d;
  logic [CW-1:0]       rptr_q;
  logic [CW-1:0]       rptr_d;
  logic                out_valid_q;
  bal_pkg::out_item_t  out_q;
  bal_pkg::out_item_t  out_d;

  bal_pkg::in_item_t   item;
  logic                accept;
  logic                full;
  logic                empty;
  logic [CMP_W-1:0]    idx_c;
  logic [CMP_W-1:0]    cnt_c;
  logic [CW-1:0]       ins_pos;
  logic [CW-1:0]       acc_pos;
  logic [CW-1:0]       rd_pos;
  logic [CMP_W-1:0]    cnt_ext;
  bal_pkg::rec_t       new_rec;
  bal_pkg::rec_t       rd_rec;
  logic                give_rec;
  bal_pkg::status_e    status;

  bal_pkg::cell_ctrl_t cell_ctrl [CAPACITY];
  bal_pkg::rec_t       cell_rec  [CAPACITY];
  bal_pkg::rec_t       cell_rd   [CAPACITY];

  assign item     = in_i.data;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);
  assign idx_c = CMP_W'(item.index);
  assign cnt_c = CMP_W'(count_q);

  assign ins_pos = (idx_c > cnt_c) ? count_q : idx_c[CW-1:0];
  assign acc_pos = (idx_c >= cnt_c) ? (count_q - CW'(1)) : idx_c[CW-1:0];
  assign rd_pos  = (bal_pkg::op_kind_e'(item.kind) == bal_pkg::OP_READ_NEXT)
                   ? rptr_q : acc_pos;

  assign new_rec = '{x: item.pos_x, y: item.pos_y, num: item.pos_num,
                     flag: item.pos_flag, symbol: item.pos_symbol};

  always_comb begin
    for (int i = 0; i < int'(CAPACITY); i++) begin
      cell_ctrl[i].op  = bal_pkg::CELL_HOLD;
      cell_ctrl[i].hit = (rd_pos == CW'(i));
      if (accept) begin
        unique case (bal_pkg::op_kind_e'(item.kind))
          bal_pkg::OP_INSERT: begin
            if (!full) begin
              if (CW'(i) > ins_pos) begin
                cell_ctrl[i].op = bal_pkg::CELL_SHIFT_UP;
              end else if (CW'(i) == ins_pos) begin
                cell_ctrl[i].op = bal_pkg::CELL_LOAD;
              end
            end
          end
          bal_pkg::OP_REMOVE: begin
            if (!empty && CW'(i) >= acc_pos) begin
              cell_ctrl[i].op = bal_pkg::CELL_SHIFT_DOWN;
            end
          end
          bal_pkg::OP_SET: begin
            if (!empty && CW'(i) == acc_pos) begin
              cell_ctrl[i].op = bal_pkg::CELL_LOAD;
            end
          end
          default: cell_ctrl[i].op = bal_pkg::CELL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < int'(CAPACITY); g++) begin : g_cell
    bal_pkg::rec_t lower_rec;
    bal_pkg::rec_t upper_rec;
    if (g == 0) begin : g_first
      assign lower_rec = cell_rec[g];
    end else begin : g_mid_lo
      assign lower_rec = cell_rec[g-1];
    end
    if (g == int'(CAPACITY) - 1) begin : g_last
      assign upper_rec = cell_rec[g];
    end else begin : g_mid_hi
      assign upper_rec = cell_rec[g+1];
    end
    bal_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .new_rec_i   (new_rec),
      .lower_rec_i (lower_rec),
      .upper_rec_i (upper_rec),
      .rec_o       (cell_rec[g]),
      .rd_rec_o    (cell_rd[g])
    );
  end

  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      rd_rec = rd_rec | cell_rd[i];
    end
  end

  always_comb begin
    count_d  = count_q;
    rptr_d   = rptr_q;
    status   = bal_pkg::ST_OK;
    give_rec = 1'b0;
    unique case (bal_pkg::op_kind_e'(item.kind))
      bal_pkg::OP_INSERT: begin
        if (full) begin
          status = bal_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      bal_pkg::OP_REMOVE: begin
        if (empty) begin
          status = bal_pkg::ST_EMPTY;
        end else begin
          count_d  = count_q - CW'(1);
          give_rec = 1'b1;
        end
      end
      bal_pkg::OP_GET: begin
        if (empty) begin
          status = bal_pkg::ST_EMPTY;
        end else begin
          give_rec = 1'b1;
        end
      end
      bal_pkg::OP_SET: begin
        if (empty) begin
          status = bal_pkg::ST_EMPTY;
        end
      end
      bal_pkg::OP_READ_NEXT: begin
        if (rptr_q >= count_q) begin
          rptr_d = '0;
          status = bal_pkg::ST_END;
        end else begin
          rptr_d   = rptr_q + CW'(1);
          give_rec = 1'b1;
        end
      end
      bal_pkg::OP_RESET_PTR: rptr_d = '0;
      default:               status = bal_pkg::ST_OK;
    endcase
  end

  assign cnt_ext = CMP_W'(count_d);

  always_comb begin
    out_d        = '0;
    out_d.status = status;
    out_d.count  = cnt_ext[IW-1:0];
    if (give_rec) begin
      out_d.out_x      = rd_rec.x;
      out_d.out_y      = rd_rec.y;
      out_d.out_num    = rd_rec.num;
      out_d.out_flag   = rd_rec.flag;
      out_d.out_symbol = rd_rec.symbol;
    end else if (status != bal_pkg::ST_OK) begin
      out_d.out_x = bal_pkg::BAD_X;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rptr_q      <= rptr_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "count above capacity")
  `ASSERT_NEXT(a_insert_grows,
    accept && item.kind == bal_pkg::OP_INSERT && !full,
    count_q == $past(count_q) + CW'(1), "insert did not grow count")
  `ASSERT_NEXT(a_remove_shrinks,
    accept && item.kind == bal_pkg::OP_REMOVE && !empty,
    count_q == $past(count_q) - CW'(1), "remove did not shrink count")
  `ASSERT_SAME(a_full_status,
    out_valid_q && out_q.status == bal_pkg::ST_FULL,
    count_q == CW'(CAPACITY), "full status with room left")

endmodule
